// File: design/fspa_pkg.sv
package fspa_pkg;

    localparam int MAX_SLOTS       = 1024;
    localparam int ADDR_BITS       = 32;
    localparam int LINK_ALIGN_LOG2 = 3;

    localparam int SLOT_W          = 17;
    localparam int ALIGN_W         = 4;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int MIN_SLOT_BYTES  = 8;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REFILL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_ALIGNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ALIGN_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH   = 2'd3;

    localparam logic [SLOT_W-1:0]  SLOT_BYTES_RESET  = 17'd8;
    localparam logic [ALIGN_W-1:0] SLOT_ALIGN_RESET  = 4'd3;

    typedef struct packed {
        logic start;
        logic step;
    } fspa_carve_ctrl_t;

endpackage

// File: design/fspa_channels.sv
interface fspa_req_if #(
    parameter int ADDR_BITS = fspa_pkg::ADDR_BITS
);
    logic                          valid;
    logic                          ready;
    logic [fspa_pkg::OP_W-1:0]     op;
    logic [fspa_pkg::SLOT_W-1:0]   want_bytes;
    logic [fspa_pkg::ALIGN_W-1:0]  want_align_log2;
    logic [ADDR_BITS-1:0]          slot_address;

    modport source (output valid, op, want_bytes, want_align_log2, slot_address,
                    input ready);
    modport sink (input valid, op, want_bytes, want_align_log2, slot_address,
                  output ready);
endinterface

interface fspa_rsp_if #(
    parameter int ADDR_BITS = fspa_pkg::ADDR_BITS,
    parameter int CNT_W     = $clog2(fspa_pkg::MAX_SLOTS + 1)
);
    logic                           valid;
    logic                           ready;
    logic [fspa_pkg::STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0]           granted_address;
    logic [CNT_W-1:0]               free_count;

    modport source (output valid, status, granted_address, free_count,
                    input ready);
    modport sink (input valid, status, granted_address, free_count,
                  output ready);
endinterface

// File: design/fspa_stack_mem.sv
module fspa_stack_mem #(
    parameter int DEPTH = fspa_pkg::MAX_SLOTS,
    parameter int WIDTH = fspa_pkg::ADDR_BITS,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fspa_carver.sv
module fspa_carver #(
    parameter int ADDR_BITS = fspa_pkg::ADDR_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fspa_pkg::fspa_carve_ctrl_t   ctrl,
    input  logic [ADDR_BITS-1:0]         region_base,
    input  logic [ADDR_BITS-1:0]         region_length,
    input  logic [fspa_pkg::SLOT_W-1:0]  slot_bytes,
    input  logic [fspa_pkg::ALIGN_W-1:0] align_log2,
    output logic                         fit,
    output logic [ADDR_BITS-1:0]         slot_addr
);

    localparam int NEED_W = ((ADDR_BITS > fspa_pkg::SLOT_W) ? ADDR_BITS : fspa_pkg::SLOT_W) + 1;

    logic [ADDR_BITS-1:0] cur_reg, cur_next;
    logic [ADDR_BITS-1:0] rem_reg, rem_next;
    logic [ADDR_BITS-1:0] align_mask;
    logic [ADDR_BITS-1:0] pad;
    logic [NEED_W-1:0]    need;

    always_comb
    begin
        align_mask = ~({ADDR_BITS{1'b1}} << align_log2);
        pad        = (~cur_reg + ADDR_BITS'(1)) & align_mask;
        need       = NEED_W'(pad) + NEED_W'(slot_bytes);
        fit        = NEED_W'(rem_reg) >= need;
        slot_addr  = cur_reg + pad;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        if (ctrl.start)
        begin
            cur_next = region_base;
            rem_next = region_length;
        end
        else if (ctrl.step && fit)
        begin
            cur_next = slot_addr + ADDR_BITS'(slot_bytes);
            rem_next = ADDR_BITS'(NEED_W'(rem_reg) - need);
        end
    end

    // cur_reg keeps the stop point of the last walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// File: design/fixed_slot_pool_allocator_unit.sv
// Allocate: a pop passes the stack memory read register, then the response register;
// a failed check goes straight into the response register.
// Free and unknown op: straight to the response register (one stack write on a free).
// Refill: one slot carved per cycle, set by the single stack write port.
// One request at a time; the result register lets the next request in while it waits.
// Reset: free set empty, configuration at 8 / 3 / 0 / 0, stack contents undefined.
module fixed_slot_pool_allocator_unit #(
    parameter int MAX_SLOTS       = fspa_pkg::MAX_SLOTS,
    parameter int ADDR_BITS       = fspa_pkg::ADDR_BITS,
    parameter int LINK_ALIGN_LOG2 = fspa_pkg::LINK_ALIGN_LOG2,
    parameter int CNT_W           = $clog2(MAX_SLOTS + 1),
    parameter int CFG_W           = (ADDR_BITS > fspa_pkg::SLOT_W) ? ADDR_BITS : fspa_pkg::SLOT_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_wdata,
    fspa_req_if.sink                       req,
    fspa_rsp_if.source                     rsp
);

    localparam int IDX_W = $clog2(MAX_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [fspa_pkg::SLOT_W-1:0]  slot_bytes_reg;
    logic [fspa_pkg::ALIGN_W-1:0] slot_align_reg;
    logic [ADDR_BITS-1:0]         region_base_reg;
    logic [ADDR_BITS-1:0]         region_length_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] top_inc, top_dec;

    logic [fspa_pkg::SLOT_W-1:0]  eff_size;
    logic [fspa_pkg::ALIGN_W-1:0] eff_align;

    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [ADDR_BITS-1:0] mem_wdata, mem_rdata;

    fspa_pkg::fspa_carve_ctrl_t carve_ctrl;
    logic                       carve_fit;
    logic [ADDR_BITS-1:0]       carve_addr;

    logic                            room, req_fire, out_free;
    logic                            res_valid;
    logic [fspa_pkg::STATUS_W-1:0]   res_status;
    logic [ADDR_BITS-1:0]            res_granted;
    logic [CNT_W-1:0]                res_count;

    logic [fspa_pkg::STATUS_W-1:0]   pend_status_reg;
    logic [ADDR_BITS-1:0]            pend_granted_reg;
    logic [CNT_W-1:0]                pend_count_reg;

    logic                            rsp_valid_reg;
    logic [fspa_pkg::STATUS_W-1:0]   rsp_status_reg;
    logic [ADDR_BITS-1:0]            rsp_granted_reg;
    logic [CNT_W-1:0]                rsp_count_reg;

    fspa_stack_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (ADDR_BITS),
        .IDX_W (IDX_W)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fspa_carver #(
        .ADDR_BITS (ADDR_BITS)
    ) u_carver (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (carve_ctrl),
        .region_base   (region_base_reg),
        .region_length (region_length_reg),
        .slot_bytes    (eff_size),
        .align_log2    (eff_align),
        .fit           (carve_fit),
        .slot_addr     (carve_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bytes_reg    <= fspa_pkg::SLOT_BYTES_RESET;
            slot_align_reg    <= fspa_pkg::SLOT_ALIGN_RESET;
            region_base_reg   <= '0;
            region_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fspa_pkg::CFG_SLOT_BYTES:
                    slot_bytes_reg <= cfg_wdata[fspa_pkg::SLOT_W-1:0];
                fspa_pkg::CFG_SLOT_ALIGN_LOG2:
                    slot_align_reg <= cfg_wdata[fspa_pkg::ALIGN_W-1:0];
                fspa_pkg::CFG_REGION_BASE:
                    region_base_reg <= cfg_wdata[ADDR_BITS-1:0];
                fspa_pkg::CFG_REGION_LENGTH:
                    region_length_reg <= cfg_wdata[ADDR_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    assign eff_size  = (slot_bytes_reg < fspa_pkg::SLOT_W'(fspa_pkg::MIN_SLOT_BYTES))
                     ? fspa_pkg::SLOT_W'(fspa_pkg::MIN_SLOT_BYTES) : slot_bytes_reg;
    assign eff_align = (slot_align_reg < fspa_pkg::ALIGN_W'(LINK_ALIGN_LOG2))
                     ? fspa_pkg::ALIGN_W'(LINK_ALIGN_LOG2) : slot_align_reg;

    assign room      = top_reg < CNT_W'(MAX_SLOTS);
    assign top_inc   = top_reg + CNT_W'(1);
    assign top_dec   = top_reg - CNT_W'(1);
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // reads and writes never share a cycle, so no forwarding is needed
    always_comb
    begin
        state_next       = state_reg;
        top_next         = top_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        carve_ctrl.start = 1'b0;
        carve_ctrl.step  = 1'b0;
        res_valid        = 1'b0;
        res_status       = fspa_pkg::ST_OK;
        res_granted      = '0;
        res_count        = top_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.op)
                        fspa_pkg::OP_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res_status = fspa_pkg::ST_EMPTY;
                            end
                            else if (req.want_bytes > eff_size)
                            begin
                                res_valid  = 1'b1;
                                res_status = fspa_pkg::ST_TOO_LARGE;
                            end
                            else if (req.want_align_log2 > eff_align)
                            begin
                                res_valid  = 1'b1;
                                res_status = fspa_pkg::ST_OVER_ALIGNED;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = top_dec[IDX_W-1:0];
                                top_next   = top_dec;
                                state_next = S_ALLOC;
                            end
                        end
                        fspa_pkg::OP_FREE:
                        begin
                            res_valid = 1'b1;
                            if (room)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = top_reg[IDX_W-1:0];
                                mem_wdata = req.slot_address;
                                top_next  = top_inc;
                                res_count = top_inc;
                            end
                            else
                            begin
                                res_status = fspa_pkg::ST_FULL;
                            end
                        end
                        fspa_pkg::OP_REFILL:
                        begin
                            carve_ctrl.start = 1'b1;
                            top_next         = '0;
                            state_next       = S_WALK;
                        end
                        default:
                            res_valid = 1'b1;
                    endcase
                end
            end
            S_ALLOC:
            begin
                res_valid   = 1'b1;
                res_granted = mem_rdata;
            end
            S_WALK:
            begin
                if (room && carve_fit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = top_reg[IDX_W-1:0];
                    mem_wdata       = carve_addr;
                    top_next        = top_inc;
                    carve_ctrl.step = 1'b1;
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
            S_HOLD:
            begin
                res_valid   = 1'b1;
                res_status  = pend_status_reg;
                res_granted = pend_granted_reg;
                res_count   = pend_count_reg;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (res_valid)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            if (res_valid && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            rsp_status_reg  <= res_status;
            rsp_granted_reg <= res_granted;
            rsp_count_reg   <= res_count;
        end
        if (res_valid && !out_free)
        begin
            pend_status_reg  <= res_status;
            pend_granted_reg <= res_granted;
            pend_count_reg   <= res_count;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.granted_address = rsp_granted_reg;
    assign rsp.free_count      = rsp_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_W'(MAX_SLOTS))
        else $error("free count above pool depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("stack read and write in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == S_ALLOC) && (top_reg == $past(top_reg) - CNT_W'(1)))
        else $error("allocate read without pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> rsp_valid_reg)
        else $error("result held while output register empty");

endmodule
